FILE: src/sam_pkg.sv
// shared types, constants and tables for the spectral angle mapper
package sam_pkg;

  localparam int MAX_BANDS       = 256;
  localparam int SAMPLE_BITS     = 16;
  localparam int ANGLE_FRAC_BITS = 14;
  localparam int BAND_AW         = $clog2(MAX_BANDS);
  localparam int REF_W           = SAMPLE_BITS + 1;
  localparam int DOT_BITS        = 40;
  localparam int NORM_BITS       = 39;
  localparam int CNT_BITS        = 9;
  localparam int WORK_FRAC       = 20;
  localparam int RND_SH          = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int CORDIC_STEPS    = 21;
  localparam int SQ_STEPS        = 32;
  localparam int DIV_STEPS       = 54;

  localparam logic [23:0] HALF_PI_Q20 = 24'd1647099;
  localparam logic [23:0] PI_Q20      = 24'd3294199;
  localparam logic [30:0] COS_ONE     = 31'h4000_0000;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam logic [1:0] SQ_PIX = 2'd0;
  localparam logic [1:0] SQ_REF = 2'd1;
  localparam logic [1:0] SQ_SIN = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_CHK,
    S_ANG
  } top_state_t;

  typedef enum logic [3:0] {
    A_IDLE,
    A_SQ,
    A_MUL,
    A_DVI,
    A_DIV,
    A_CSQ,
    A_CORD,
    A_FIN,
    A_DONE
  } ang_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } ang_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ang_sts_t;

  function automatic logic [19:0] atan_q20(input logic [4:0] i);
    logic [19:0] v;
    case (i)
      5'd0:    v = 20'd823550;
      5'd1:    v = 20'd486170;
      5'd2:    v = 20'd256879;
      5'd3:    v = 20'd130396;
      5'd4:    v = 20'd65451;
      5'd5:    v = 20'd32757;
      5'd6:    v = 20'd16383;
      5'd7:    v = 20'd8192;
      5'd8:    v = 20'd4096;
      5'd9:    v = 20'd2048;
      5'd10:   v = 20'd1024;
      5'd11:   v = 20'd512;
      5'd12:   v = 20'd256;
      5'd13:   v = 20'd128;
      5'd14:   v = 20'd64;
      5'd15:   v = 20'd32;
      5'd16:   v = 20'd16;
      5'd17:   v = 20'd8;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      5'd20:   v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/sam_ram.sv
// generic single-port-write, registered-read ram
module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/sam_angle.sv
// iterative angle unit: square roots, divide, sine and cordic arccosine
module sam_angle
  import sam_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  ang_ctl_t                    ctl,
  input  logic signed [DOT_BITS-1:0]  dot,
  input  logic [NORM_BITS-1:0]        pix_norm,
  input  logic [NORM_BITS-1:0]        ref_norm,
  output ang_sts_t                    sts,
  output logic [15:0]                 angle
);

  ang_state_t state, state_next;

  logic [DOT_BITS-1:0]  mag;
  logic                 neg;
  logic [NORM_BITS-1:0] ref_n;
  logic [1:0]           sq_sel;
  logic [63:0]          rad;
  logic [31:0]          root;
  logic [35:0]          rem;
  logic [31:0]          u_pix;
  logic [63:0]          d;
  logic [64:0]          r;
  logic [54:0]          q;
  logic [30:0]          cmag;
  logic signed [32:0]   x, y;
  logic signed [23:0]   z;
  logic [5:0]           cnt;

  // one bit of the square root per cycle
  logic [35:0] rem_sh, trial;
  logic        sq_ge;
  logic [31:0] root_nx;
  logic [35:0] rem_nx;
  assign rem_sh  = {rem[33:0], rad[63:62]};
  assign trial   = {2'b00, root, 2'b01};
  assign sq_ge   = rem_sh >= trial;
  assign root_nx = {root[30:0], sq_ge};
  assign rem_nx  = sq_ge ? rem_sh - trial : rem_sh;

  // one quotient bit per cycle
  logic [64:0] r_sh;
  logic        dv_ge;
  logic [54:0] q_nx;
  assign r_sh  = {r[63:0], 1'b0};
  assign dv_ge = r_sh >= {1'b0, d};
  assign q_nx  = {q[53:0], dv_ge};

  logic [61:0] csq;
  assign csq = cmag * cmag;

  logic signed [32:0] xs, ys;
  logic [19:0]        at;
  assign xs = x >>> cnt[4:0];
  assign ys = y >>> cnt[4:0];
  assign at = atan_q20(cnt[4:0]);

  logic signed [23:0] zc;
  logic [23:0]        zr;
  always_comb begin
    if (z < 0) begin
      zc = '0;
    end else if (z > $signed(PI_Q20)) begin
      zc = $signed(PI_Q20);
    end else begin
      zc = z;
    end
    zr = unsigned'(zc) + (24'(1) << (RND_SH - 1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      A_IDLE: if (ctl.start) state_next = A_SQ;
      A_SQ: begin
        if (cnt == 6'(SQ_STEPS - 1)) begin
          if (sq_sel == SQ_PIX) begin
            state_next = A_SQ;
          end else if (sq_sel == SQ_REF) begin
            state_next = A_MUL;
          end else begin
            state_next = A_CORD;
          end
        end
      end
      A_MUL: state_next = A_DVI;
      A_DVI: state_next = ({24'b0, mag} >= d) ? A_CSQ : A_DIV;
      A_DIV: if (cnt == 6'(DIV_STEPS - 1)) state_next = A_CSQ;
      A_CSQ: state_next = A_SQ;
      A_CORD: if (cnt == 6'(CORDIC_STEPS - 1)) state_next = A_FIN;
      A_FIN: state_next = A_DONE;
      A_DONE: if (ctl.ack) state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  always_comb begin
    sts.idle = (state == A_IDLE);
    sts.done = (state == A_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        if (ctl.start) begin
          neg    <= dot[DOT_BITS-1];
          mag    <= dot[DOT_BITS-1] ? DOT_BITS'(-dot) : DOT_BITS'(dot);
          ref_n  <= ref_norm;
          rad    <= {1'b0, pix_norm, 24'b0};
          root   <= '0;
          rem    <= '0;
          cnt    <= '0;
          sq_sel <= SQ_PIX;
        end
      end
      A_SQ: begin
        rad  <= {rad[61:0], 2'b00};
        root <= root_nx;
        rem  <= rem_nx;
        cnt  <= cnt + 6'd1;
        if (cnt == 6'(SQ_STEPS - 1)) begin
          cnt <= '0;
          if (sq_sel == SQ_PIX) begin
            u_pix  <= root_nx;
            rad    <= {1'b0, ref_n, 24'b0};
            root   <= '0;
            rem    <= '0;
            sq_sel <= SQ_REF;
          end else if (sq_sel == SQ_SIN) begin
            // negative nonzero cosine: rotate by a quarter turn before the cordic
            if (neg && cmag != '0) begin
              x <= 33'(root_nx);
              y <= 33'(cmag);
              z <= $signed(HALF_PI_Q20);
            end else begin
              x <= 33'(cmag);
              y <= 33'(root_nx);
              z <= '0;
            end
          end
        end
      end
      A_MUL: d <= u_pix * root;
      A_DVI: begin
        r   <= {25'b0, mag};
        q   <= '0;
        cnt <= '0;
        if ({24'b0, mag} >= d) begin
          cmag <= COS_ONE;
        end
      end
      A_DIV: begin
        r   <= dv_ge ? r_sh - {1'b0, d} : r_sh;
        q   <= q_nx;
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_STEPS - 1)) begin
          cmag <= (q_nx > 55'(COS_ONE)) ? COS_ONE : q_nx[30:0];
          cnt  <= '0;
        end
      end
      A_CSQ: begin
        rad    <= {4'b0001, 60'b0} - {2'b00, csq};
        root   <= '0;
        rem    <= '0;
        cnt    <= '0;
        sq_sel <= SQ_SIN;
      end
      A_CORD: begin
        if (!y[32]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + $signed({4'b0, at});
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - $signed({4'b0, at});
        end
        cnt <= cnt + 6'd1;
      end
      A_FIN: angle <= 16'(zr >> RND_SH);
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_cmag_range: assert property (@(posedge clk) disable iff (rst)
    (state == A_CORD) |-> (cmag <= COS_ONE))
    else $error("cosine magnitude above one");
  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == A_DIV) |-> (cnt < 6'(DIV_STEPS)))
    else $error("divide step count out of range");
  a_cord_steps: assert property (@(posedge clk) disable iff (rst)
    (state == A_CORD) |-> (cnt < 6'(CORDIC_STEPS)))
    else $error("cordic step count out of range");
`endif

endmodule

FILE: src/spectral_angle_mapper.sv
// spectral angle mapper top level: reference store, accumulators, result register
// a reference load is written to the store when accepted; a pixel band that is not last
// is accumulated and returns to idle; a last pixel band runs the iterative angle unit
// (three 32-step square roots, a 54-step divide, 21 cordic steps), with no divide when |cos| is 1,
// and skips the unit when the result is flagged invalid; a stalled output adds its wait
// reset clears the accumulators, the control state and the output valid flag;
// the reference store is not cleared and must be loaded before use
module spectral_angle_mapper
  import sam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // band_index[7:0], sample_value[23:8], sample_valid[24]
  input  logic        s_axis_tuser,  // req_type
  input  logic        s_axis_tlast,  // last_band
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // angle[15:0]
  output logic        m_axis_tuser   // angle_valid
);

  top_state_t state, state_next;

  logic [7:0]                    in_idx;
  logic signed [SAMPLE_BITS-1:0] in_val;
  logic                          in_ok;
  logic                          in_range;
  assign in_idx   = s_axis_tdata[7:0];
  assign in_val   = s_axis_tdata[23:8];
  assign in_ok    = s_axis_tdata[24];
  assign in_range = {1'b0, in_idx} < 9'(MAX_BANDS);

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          ok_r;
  logic                          last_r;
  logic                          range_r;

  logic signed [DOT_BITS-1:0] dot_acc;
  logic [NORM_BITS-1:0]       pix_acc;
  logic [NORM_BITS-1:0]       ref_acc;
  logic [CNT_BITS-1:0]        band_cnt;

  logic                ram_we;
  logic [REF_W-1:0]    ram_rdata;

  sam_ram #(
    .WIDTH(REF_W),
    .DEPTH(MAX_BANDS)
  ) u_ref_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_idx[BAND_AW-1:0]),
    .wdata({in_ok, in_val}),
    .raddr(in_idx[BAND_AW-1:0]),
    .rdata(ram_rdata)
  );

  ang_ctl_t    ang_ctl;
  ang_sts_t    ang_sts;
  logic [15:0] ang_angle;

  sam_angle u_angle (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ang_ctl),
    .dot     (dot_acc),
    .pix_norm(pix_acc),
    .ref_norm(ref_acc),
    .sts     (ang_sts),
    .angle   (ang_angle)
  );

  logic signed [SAMPLE_BITS-1:0]   ref_val;
  logic                            hit;
  logic signed [2*SAMPLE_BITS-1:0] p_dot, p_pix, p_ref;
  assign ref_val = ram_rdata[SAMPLE_BITS-1:0];
  assign hit     = ok_r && range_r && ram_rdata[REF_W-1];
  assign p_dot   = sample_r * ref_val;
  assign p_pix   = sample_r * sample_r;
  assign p_ref   = ref_val * ref_val;

  logic out_free;
  logic invalid;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign invalid  = (band_cnt < CNT_BITS'(2)) || (pix_acc == '0) || (ref_acc == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && s_axis_tuser == REQ_PIXEL) state_next = S_ACC;
      S_ACC:  state_next = last_r ? S_CHK : S_IDLE;
      S_CHK: begin
        if (invalid) begin
          if (out_free) state_next = S_IDLE;
        end else begin
          state_next = S_ANG;
        end
      end
      S_ANG:  if (ang_sts.done && out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic load_inv, load_ang, acc_clear;
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    ram_we        = accept && s_axis_tuser == REQ_LOAD && in_range;
    ang_ctl.start = (state == S_CHK) && !invalid;
    ang_ctl.ack   = (state == S_ANG) && ang_sts.done && out_free;
    load_inv      = (state == S_CHK) && invalid && out_free;
    load_ang      = ang_ctl.ack;
    acc_clear     = ang_ctl.start || load_inv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_val;
      ok_r     <= in_ok;
      last_r   <= s_axis_tlast;
      range_r  <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || acc_clear) begin
      dot_acc  <= '0;
      pix_acc  <= '0;
      ref_acc  <= '0;
      band_cnt <= '0;
    end else if (state == S_ACC && hit) begin
      dot_acc <= dot_acc + DOT_BITS'(p_dot);
      pix_acc <= pix_acc + NORM_BITS'(unsigned'(p_pix));
      ref_acc <= ref_acc + NORM_BITS'(unsigned'(p_ref));
      if (band_cnt != '1) begin
        band_cnt <= band_cnt + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_inv || load_ang) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_inv) begin
      m_axis_tdata <= '0;
      m_axis_tuser <= 1'b0;
    end else if (load_ang) begin
      m_axis_tdata <= ang_angle;
      m_axis_tuser <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ang_ctl.start |-> ang_sts.idle)
    else $error("angle unit started while busy");
  a_ack_done: assert property (@(posedge clk) disable iff (rst)
    ang_ctl.ack |-> ang_sts.done)
    else $error("angle taken before it is ready");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 16'd0))
    else $error("invalid angle carries a nonzero value");
  a_angle_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata <= 16'd51472))
    else $error("angle above pi");
`endif

endmodule
